// ===== design/psrg_pkg.sv =====
// ----------------------------------------------------------------------------
// psrg_pkg
// Shared types and constants of the packet sequence and rate gate.
// ----------------------------------------------------------------------------
package psrg_pkg;

    localparam int SEQ_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int MSG_W   = 17;
    localparam int BYTE_W  = 25;
    localparam int WIN_W   = 16;
    localparam int MAXM_W  = 16;
    localparam int MAXB_W  = 24;
    localparam int SWIN_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    localparam int PSRG_QUEUE_DEPTH = 2;

    localparam logic [MSG_W-1:0]  MSG_MAX  = '1;
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

    localparam logic [WIN_W-1:0]  RST_WINDOW_MS   = 16'd1000;
    localparam logic [MAXM_W-1:0] RST_MAX_MSG     = 16'd50;
    localparam logic [MAXB_W-1:0] RST_MAX_BYTES   = 24'd65536;
    localparam logic [SWIN_W-1:0] RST_SEQ_WINDOW  = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_RATE  = 3'd4;

    typedef enum logic [1:0] {
        V_ACCEPT   = 2'd0,
        V_SEQ_REJ  = 2'd1,
        V_RATE_REJ = 2'd2,
        V_CLOSED   = 2'd3
    } t_verdict;

    // classified word handed from front to back
    typedef struct packed {
        logic              seq_ok;
        logic [SIZE_W-1:0] pkt_len;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic gate_closed;
    } t_back_stat;

endpackage

// ===== design/psrg_req_if.sv =====
// ----------------------------------------------------------------------------
// psrg_req_if
// Valid/ready channel carrying one received packet header.
// ----------------------------------------------------------------------------
interface psrg_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] sequence_req;
    logic [15:0] pkt_len;
    logic [31:0] now_ms;

    modport source (output valid, output sequence_req, output pkt_len,
                    output now_ms, input ready);
    modport sink   (input valid, input sequence_req, input pkt_len,
                    input now_ms, output ready);
endinterface

// ===== design/psrg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psrg_rsp_if
// Valid/ready channel carrying one admission verdict with window counters.
// ----------------------------------------------------------------------------
interface psrg_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [16:0] messages_in_window;
    logic [24:0] bytes_in_window;

    modport source (output valid, output verdict, output messages_in_window,
                    output bytes_in_window, input ready);
    modport sink   (input valid, input verdict, input messages_in_window,
                    input bytes_in_window, output ready);
endinterface

// ===== design/packet_sequence_and_rate_gate.sv =====
// ----------------------------------------------------------------------------
// packet_sequence_and_rate_gate
// Admits packets of one session: sequence window check, fixed-window rate
// limit, and a gate that closes for good on the first rejection.
// ----------------------------------------------------------------------------
//  port     dir  handshake     word
//  i_req    in   valid/ready   sequence_req, pkt_len, now_ms
//  o_rsp    out  valid/ready   verdict, messages_in_window, bytes_in_window
//  i_cfg_*  in   write enable  register index, data (24 bits)
//
//  One word per cycle sustained while o_rsp is not stalled; a taken word is
//  written into the queue, then into the result register, and so shows on o_rsp.
//  The back's window/counter update is the registered loop that sets the rate.
//  i_req.ready drops only when the queue is full, i.e. o_rsp has stalled.
//  Synchronous active-low reset opens the gate, clears counters and loads
//  default register values.
// ----------------------------------------------------------------------------
module packet_sequence_and_rate_gate #(
    parameter int QUEUE_DEPTH = psrg_pkg::PSRG_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    psrg_req_if.sink                       i_req,
    psrg_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [psrg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [psrg_pkg::CFG_W-1:0]     i_cfg_data
);
    import psrg_pkg::*;

    logic [WIN_W-1:0]  r_window_ms;
    logic [MAXM_W-1:0] r_max_messages;
    logic [MAXB_W-1:0] r_max_bytes;
    logic [SWIN_W-1:0] r_seq_window;
    logic              r_bypass;

    logic       q_full;
    logic       q_push;
    t_item      q_in;
    logic       q_valid;
    t_item      q_out;
    logic       q_pop;
    t_verdict   verdict;
    t_back_stat bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms    <= RST_WINDOW_MS;
            r_max_messages <= RST_MAX_MSG;
            r_max_bytes    <= RST_MAX_BYTES;
            r_seq_window   <= RST_SEQ_WINDOW;
            r_bypass       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_MS:    r_window_ms    <= i_cfg_data[WIN_W-1:0];
                CFG_MAX_MESSAGES: r_max_messages <= i_cfg_data[MAXM_W-1:0];
                CFG_MAX_BYTES:    r_max_bytes    <= i_cfg_data[MAXB_W-1:0];
                CFG_SEQ_WINDOW:   r_seq_window   <= i_cfg_data[SWIN_W-1:0];
                CFG_BYPASS_RATE:  r_bypass       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    psrg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .i_seq        (i_req.sequence_req),
        .i_size       (i_req.pkt_len),
        .i_now        (i_req.now_ms),
        .o_ready      (i_req.ready),
        .i_seq_window (r_seq_window),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_item       (q_in)
    );

    psrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    psrg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_out),
        .o_pop          (q_pop),
        .i_window_ms    (r_window_ms),
        .i_max_messages (r_max_messages),
        .i_max_bytes    (r_max_bytes),
        .i_bypass       (r_bypass),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_verdict      (verdict),
        .o_messages     (o_rsp.messages_in_window),
        .o_bytes        (o_rsp.bytes_in_window),
        .o_stat         (bstat)
    );

    assign o_rsp.verdict = verdict;

    // the gate never reopens short of reset
    a_gate_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.gate_closed |=> bstat.gate_closed)
        else $error("gate reopened");

    // any non-accept verdict on the output means the gate is closed
    a_reject_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (verdict != V_ACCEPT) |-> bstat.gate_closed)
        else $error("rejection shown with gate open");

    // a counted accept always carries at least this word
    a_accept_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (verdict == V_ACCEPT) && !r_bypass
            |-> (o_rsp.messages_in_window != '0))
        else $error("accepted word not counted");

endmodule

// ===== design/psrg_front.sv =====
// ----------------------------------------------------------------------------
// psrg_front
// Accepts packet headers and runs the modulo 2^16 sequence window check.
// ----------------------------------------------------------------------------
module psrg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [psrg_pkg::SEQ_W-1:0]  i_seq,
    input  logic [psrg_pkg::SIZE_W-1:0] i_size,
    input  logic [psrg_pkg::TIME_W-1:0] i_now,
    output logic                       o_ready,
    input  logic [psrg_pkg::SWIN_W-1:0] i_seq_window,
    input  logic                       i_q_full,
    output logic                       o_push,
    output psrg_pkg::t_item            o_item
);
    import psrg_pkg::*;

    logic [SEQ_W-1:0] r_last;
    logic [SEQ_W-1:0] n_last;
    logic [SEQ_W-1:0] fwd;
    logic [SEQ_W-1:0] bwd;
    logic             fwd_zero;
    logic             fwd_in;
    logic             bwd_in;

    assign fwd      = i_seq - r_last;
    assign bwd      = r_last - i_seq;
    assign fwd_zero = (fwd == '0);
    assign fwd_in   = (fwd < i_seq_window);
    assign bwd_in   = (bwd < i_seq_window);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign o_item.seq_ok  = fwd_zero || fwd_in || bwd_in;
    assign o_item.pkt_len = i_size;
    assign o_item.now_ms  = i_now;

    // After a closing word nothing reads r_last again, so it may move freely.
    always_comb begin
        n_last = r_last;
        if (o_push && !fwd_zero && fwd_in) begin
            n_last = i_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

// ===== design/psrg_queue.sv =====
// ----------------------------------------------------------------------------
// psrg_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module psrg_queue #(
    parameter int DEPTH = psrg_pkg::PSRG_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psrg_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output psrg_pkg::t_item o_item
);
    import psrg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/psrg_back.sv =====
// ----------------------------------------------------------------------------
// psrg_back
// Gate state, fixed-window rate limiter and the result register.
// ----------------------------------------------------------------------------
module psrg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  psrg_pkg::t_item             i_q_item,
    output logic                        o_pop,
    input  logic [psrg_pkg::WIN_W-1:0]  i_window_ms,
    input  logic [psrg_pkg::MAXM_W-1:0] i_max_messages,
    input  logic [psrg_pkg::MAXB_W-1:0] i_max_bytes,
    input  logic                        i_bypass,
    output logic                        o_valid,
    input  logic                        i_ready,
    output psrg_pkg::t_verdict          o_verdict,
    output logic [psrg_pkg::MSG_W-1:0]  o_messages,
    output logic [psrg_pkg::BYTE_W-1:0] o_bytes,
    output psrg_pkg::t_back_stat        o_stat
);
    import psrg_pkg::*;

    logic              r_gate;
    logic [TIME_W-1:0] r_start;
    logic [MSG_W-1:0]  r_msg;
    logic [BYTE_W-1:0] r_byte;
    logic              r_out_valid;
    t_verdict          r_verdict;
    logic [MSG_W-1:0]  r_out_msg;
    logic [BYTE_W-1:0] r_out_byte;

    logic              n_gate;
    logic [TIME_W-1:0] n_start;
    logic [MSG_W-1:0]  n_msg;
    logic [BYTE_W-1:0] n_byte;
    logic              n_out_valid;
    t_verdict          n_verdict;

    logic [TIME_W-1:0] elapsed;
    logic              restart;
    logic [MSG_W-1:0]  base_msg;
    logic [BYTE_W-1:0] base_byte;
    logic [MSG_W-1:0]  cnt_msg;
    logic [BYTE_W:0]   byte_sum;
    logic [BYTE_W-1:0] cnt_byte;
    logic              rate_bad;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    assign elapsed   = i_q_item.now_ms - r_start;
    assign restart   = (elapsed >= TIME_W'(i_window_ms));
    assign base_msg  = restart ? '0 : r_msg;
    assign base_byte = restart ? '0 : r_byte;
    assign cnt_msg   = (base_msg == MSG_MAX) ? MSG_MAX : base_msg + 1'b1;
    assign byte_sum  = {1'b0, base_byte} + (BYTE_W + 1)'(i_q_item.pkt_len);
    assign cnt_byte  = (byte_sum > (BYTE_W + 1)'(BYTE_MAX)) ? BYTE_MAX
                                                           : byte_sum[BYTE_W-1:0];
    assign rate_bad  = (cnt_msg > MSG_W'(i_max_messages))
                    || (cnt_byte > BYTE_W'(i_max_bytes));

    always_comb begin
        n_gate      = r_gate;
        n_start     = r_start;
        n_msg       = r_msg;
        n_byte      = r_byte;
        n_verdict   = V_ACCEPT;
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop) begin
            n_out_valid = 1'b1;
            if (r_gate) begin
                n_verdict = V_CLOSED;
            end else if (!i_q_item.seq_ok) begin
                n_verdict = V_SEQ_REJ;
                n_gate    = 1'b1;
            end else if (i_bypass) begin
                n_verdict = V_ACCEPT;
            end else begin
                if (restart) begin
                    n_start = i_q_item.now_ms;
                end
                n_msg  = cnt_msg;
                n_byte = cnt_byte;
                if (rate_bad) begin
                    n_verdict = V_RATE_REJ;
                    n_gate    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= 1'b0;
            r_start     <= '0;
            r_msg       <= '0;
            r_byte      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_gate      <= n_gate;
            r_start     <= n_start;
            r_msg       <= n_msg;
            r_byte      <= n_byte;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload; counters reported as they stand after this word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict  <= n_verdict;
            r_out_msg  <= n_msg;
            r_out_byte <= n_byte;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_verdict          = r_verdict;
    assign o_messages         = r_out_msg;
    assign o_bytes            = r_out_byte;
    assign o_stat.gate_closed = r_gate;

endmodule
